FILE: design/nibble_clut_blitter_assert.svh
// Assertion macros shared by the blitter RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef NIBBLE_CLUT_BLITTER_ASSERT_SVH
`define NIBBLE_CLUT_BLITTER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define NCB_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("blitter assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define NCB_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("blitter forbidden condition seen");

`endif

FILE: design/ncb_pkg.sv
// Shared types, constants and helper functions of the nibble lookup blitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ncb_pkg;

  localparam int unsigned RomBytes  = 262144;
  localparam int unsigned AddrW     = 18;
  localparam logic [18:0] RomLast   = 19'(RomBytes - 1);
  localparam int unsigned ResDepth  = 4;
  localparam int unsigned ResPtrW   = $clog2(ResDepth);
  localparam int unsigned ResCntW   = $clog2(ResDepth + 1);

  typedef enum logic [1:0] {
    KindFetch = 2'd0,
    KindPixel = 2'd1,
    KindDone  = 2'd2
  } kind_e;

  typedef enum logic {
    OpStart   = 1'b0,
    OpDeliver = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CfgSource = 3'd0,
    CfgDestX  = 3'd1,
    CfgDestY  = 3'd2,
    CfgSizeX  = 3'd3,
    CfgSizeY  = 3'd4,
    CfgMode   = 3'd5,
    CfgLutLow = 3'd6,
    CfgLutHi  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] source_address;
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [7:0]  size_x;
    logic [7:0]  size_y;
    logic [5:0]  mode_bits;
    logic [63:0] lut_low;
    logic [63:0] lut_high;
  } cfg_t;

  // One queued command between the front and the back.
  typedef struct packed {
    op_e        op;
    logic [7:0] rom_byte;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] cols;
    logic [7:0] rows;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] rom_address;
    logic [7:0]       pixel_x;
    logic [7:0]       pixel_y;
    logic [4:0]       pixel_color;
    logic [16:0]      pixel_count;
    logic             last;
  } res_t;

  // Up to two results per cycle; a is older than b.
  typedef struct packed {
    logic va;
    res_t a;
    logic vb;
    res_t b;
  } push_t;

  // A size of 0x80 or more folds when walking forward.
  function automatic logic [7:0] fold_size(input logic [7:0] size, input logic fwd);
    logic [7:0] r;
    r = (fwd && size[7]) ? (8'hff - size) : size;
    return r;
  endfunction

  function automatic logic [AddrW-1:0] rom_addr(input logic [1:0] bank,
                                                input logic [15:0] src,
                                                input logic [15:0] off);
    logic [18:0] sum;
    sum = {1'b0, bank, 16'h0000} + {3'b000, src} + {3'b000, off};
    return (sum > RomLast) ? '0 : sum[AddrW-1:0];
  endfunction

endpackage

FILE: design/ncb_front.sv
// Front end: accepts command beats, classifies them and precomputes the walk
// origin of a start. Holds the two-entry queue towards the back. Uses ncb_pkg.
`timescale 1ns / 1ps

module ncb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ncb_pkg::cfg_t  cfg_i,
  input  logic           push,
  output logic           full,
  input  logic           command_i,
  input  logic [7:0]     rom_byte_i,
  output logic           item_valid_o,
  output ncb_pkg::item_t item_o,
  input  logic           item_pop_i
);
  import ncb_pkg::*;

  item_t       slot_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_en;
  item_t       new_item;

  assign full         = (cnt_q == 2'd2);
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rptr_q];

  always_comb begin
    new_item.op       = command_i ? OpDeliver : OpStart;
    new_item.rom_byte = rom_byte_i;
    new_item.start_x  = cfg_i.dest_x + cfg_i.size_x;
    new_item.start_y  = cfg_i.dest_y + cfg_i.size_y;
    new_item.cols     = fold_size(cfg_i.size_x, cfg_i.mode_bits[0]);
    new_item.rows     = fold_size(cfg_i.size_y, cfg_i.mode_bits[1]);
  end

  always_comb begin
    wptr_d = wptr_q + 1'(wr_en);
    rptr_d = rptr_q + 1'(item_pop_i);
    cnt_d  = cnt_q + 2'(wr_en) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wptr_q] <= new_item;
    end
  end

endmodule

FILE: design/ncb_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per pop.
// Uses ncb_pkg for the result types and depth.
`timescale 1ns / 1ps

module ncb_res_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ncb_pkg::push_t          push_i,
  output logic                    room2_o,
  output logic                    empty,
  input  logic                    pop,
  output ncb_pkg::res_t           head_o
);
  import ncb_pkg::*;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic [1:0]         n_push;
  logic               rd_en;
  res_t               first;

  assign empty   = (cnt_q == '0);
  assign rd_en   = pop && !empty;
  assign head_o  = mem_q[rptr_q];
  assign room2_o = (cnt_q <= ResCntW'(ResDepth - 2));
  assign n_push  = 2'(push_i.va) + 2'(push_i.vb);
  assign first   = push_i.va ? push_i.a : push_i.b;

  always_comb begin
    wptr_d = wptr_q + ResPtrW'(n_push);
    rptr_d = rptr_q + ResPtrW'(rd_en);
    cnt_d  = cnt_q + ResCntW'(n_push) - ResCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wptr_q] <= first;
    end
    if (push_i.va && push_i.vb) begin
      mem_q[wptr_q + ResPtrW'(1)] <= push_i.b;
    end
  end

endmodule

FILE: design/ncb_back.sv
// Back end: walks the blit one nibble per cycle while the result queue has
// room for two, and produces the fetch, pixel and done results. Uses ncb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "nibble_clut_blitter_assert.svh"

module ncb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ncb_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  ncb_pkg::item_t item_i,
  output logic           item_pop_o,
  input  logic           room2_i,
  output ncb_pkg::push_t push_o
);
  import ncb_pkg::*;

  logic        busy_q, busy_d;
  logic        phase_q, phase_d;      // high nibble of the held byte pending
  logic [3:0]  hi_q, hi_d;
  logic [7:0]  col_q, col_d, row_q, row_d, x_q, x_d, y_q, y_d;
  logic [15:0] off_q, off_d;
  logic [16:0] walked_q, walked_d;

  logic        take, step_hi, xf, yf, flip, pal;
  logic [3:0]  nib;
  logic [7:0]  ent;
  logic        visible, at_end;
  logic [7:0]  col_n, row_n, x_n, y_n;
  logic [16:0] walked_n;
  res_t        pix_r, done_r, fetch_r, start_r;

  assign xf   = cfg_i.mode_bits[0];
  assign yf   = cfg_i.mode_bits[1];
  assign flip = cfg_i.mode_bits[2];
  assign pal  = cfg_i.mode_bits[3];

  assign step_hi    = phase_q && room2_i;
  assign take       = !phase_q && item_valid_i && room2_i;
  assign item_pop_o = take;

  // Nibble lookup: entries with an upper nibble pass the index through.
  always_comb begin
    nib = phase_q ? hi_q : item_i.rom_byte[3:0];
    ent = nib[3] ? cfg_i.lut_high[{nib[2:0], 3'b000} +: 8]
                 : cfg_i.lut_low[{nib[2:0], 3'b000} +: 8];
    if (ent[7:4] != 4'h0) begin
      visible = (nib != 4'h0);
    end else begin
      visible = (ent != 8'h00);
    end
    pix_r             = '0;
    pix_r.kind        = KindPixel;
    pix_r.pixel_x     = x_q ^ {8{flip}};
    pix_r.pixel_y     = y_q ^ {8{flip}};
    pix_r.pixel_color = {pal, (ent[7:4] != 4'h0) ? nib : ent[3:0]};
  end

  // Walk advance after the current pixel.
  always_comb begin
    walked_n = walked_q + 17'd1;
    at_end   = (col_q == 8'h00) && (row_q == 8'h00);
    col_n    = col_q;
    row_n    = row_q;
    x_n      = x_q;
    y_n      = y_q;
    if (col_q == 8'h00) begin
      if (row_q != 8'h00) begin
        row_n = row_q - 8'd1;
        col_n = fold_size(cfg_i.size_x, xf);
        x_n   = cfg_i.dest_x + cfg_i.size_x;
        y_n   = yf ? (y_q + 8'd1) : (y_q - 8'd1);
      end
    end else begin
      col_n = col_q - 8'd1;
      x_n   = xf ? (x_q + 8'd1) : (x_q - 8'd1);
    end
    done_r             = '0;
    done_r.kind        = KindDone;
    done_r.pixel_count = walked_n;
    done_r.last        = 1'b1;
    fetch_r             = '0;
    fetch_r.kind        = KindFetch;
    fetch_r.rom_address = rom_addr(cfg_i.mode_bits[5:4], cfg_i.source_address,
                                   off_q + 16'd1);
    fetch_r.last        = 1'b1;
    start_r             = '0;
    start_r.kind        = KindFetch;
    start_r.rom_address = rom_addr(cfg_i.mode_bits[5:4], cfg_i.source_address, 16'h0000);
    start_r.last        = 1'b1;
  end

  always_comb begin
    push_o   = '0;
    busy_d   = busy_q;
    phase_d  = phase_q;
    hi_d     = hi_q;
    col_d    = col_q;
    row_d    = row_q;
    x_d      = x_q;
    y_d      = y_q;
    off_d    = off_q;
    walked_d = walked_q;
    if (step_hi) begin
      push_o.va = visible;
      push_o.a  = pix_r;
      push_o.vb = 1'b1;
      push_o.b  = at_end ? done_r : fetch_r;
      busy_d    = !at_end;
      phase_d   = 1'b0;
      off_d     = off_q + 16'd1;
      walked_d  = walked_n;
      col_d     = col_n;
      row_d     = row_n;
      x_d       = x_n;
      y_d       = y_n;
    end else if (take) begin
      if (item_i.op == OpStart) begin
        push_o.vb = 1'b1;
        push_o.b  = start_r;
        busy_d    = 1'b1;
        off_d     = 16'h0000;
        walked_d  = 17'd0;
        col_d     = item_i.cols;
        row_d     = item_i.rows;
        x_d       = item_i.start_x;
        y_d       = item_i.start_y;
      end else if (busy_q) begin
        push_o.va = visible;
        push_o.a  = pix_r;
        push_o.vb = at_end;
        push_o.b  = done_r;
        busy_d    = !at_end;
        phase_d   = !at_end;
        hi_d      = item_i.rom_byte[7:4];
        walked_d  = walked_n;
        col_d     = col_n;
        row_d     = row_n;
        x_d       = x_n;
        y_d       = y_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      phase_q  <= 1'b0;
      hi_q     <= 4'h0;
      col_q    <= 8'h00;
      row_q    <= 8'h00;
      x_q      <= 8'h00;
      y_q      <= 8'h00;
      off_q    <= 16'h0000;
      walked_q <= 17'd0;
    end else begin
      busy_q   <= busy_d;
      phase_q  <= phase_d;
      hi_q     <= hi_d;
      col_q    <= col_d;
      row_q    <= row_d;
      x_q      <= x_d;
      y_q      <= y_d;
      off_q    <= off_d;
      walked_q <= walked_d;
    end
  end

  // A pending high nibble only exists inside a running walk.
  `NCB_ASSERT(a_phase_busy, clk_i, rst_ni, phase_q |-> busy_q)
  // Results are only produced when the result queue has room for two.
  `NCB_ASSERT_NEVER(a_push_room, clk_i, rst_ni, (push_o.va || push_o.vb) && !room2_i)
  // The high nibble is finished in the cycle it is given room.
  `NCB_ASSERT(a_hi_done, clk_i, rst_ni, step_hi |=> !phase_q)

endmodule

FILE: design/nibble_clut_blitter.sv
// Top level of the 4-bit-per-pixel lookup blitter: configuration registers,
// front end, back end and result queue. Uses ncb_pkg and all ncb_ modules.
// Usage:
//   Configuration is written over cfg_valid_i/cfg_ready_o (always ready) with
//   a register index and data, while no command beat is still in flight.
//   Command beats enter on push/full: command 0 starts a blit, command 1
//   delivers the ROM byte that the last fetch request asked for.
//   Results leave on empty/pop: fetch requests, pixel writes and a done
//   report per blit; last marks the final result that a command caused.
// Flow:
//   A beat in the command queue is taken by the back end when no high nibble
//   is pending and the result queue has room for two; the back end then writes
//   its first result into the result queue, whose head drives the result ports.
//   The back end handles one nibble per cycle while the result queue has room
//   for two, so a delivered byte is handled as a low and then a high nibble
//   step and a start in one step; at most three results per byte are drained
//   at one per pop, which then sets the rate.
// Reset clears all control and configuration registers and empties both queues; the block comes up idle.
// When the receiver stops popping, the result queue fills, the back end
// holds its place and the two-entry command queue then raises full.
`timescale 1ns / 1ps

module nibble_clut_blitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [63:0]                cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic                       command_i,
  input  logic [7:0]                 rom_byte_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 kind_o,
  output logic [ncb_pkg::AddrW-1:0]  rom_address_o,
  output logic [7:0]                 pixel_x_o,
  output logic [7:0]                 pixel_y_o,
  output logic [4:0]                 pixel_color_o,
  output logic [16:0]                pixel_count_o,
  output logic                       last_o
);
  import ncb_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  item_valid, item_pop, room2;
  item_t item;
  push_t res_push;
  res_t  head;

  // Configuration is always accepted; registers are read live by both ends.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSource: cfg_d.source_address = cfg_data_i[15:0];
        CfgDestX:  cfg_d.dest_x         = cfg_data_i[7:0];
        CfgDestY:  cfg_d.dest_y         = cfg_data_i[7:0];
        CfgSizeX:  cfg_d.size_x         = cfg_data_i[7:0];
        CfgSizeY:  cfg_d.size_y         = cfg_data_i[7:0];
        CfgMode:   cfg_d.mode_bits      = cfg_data_i[5:0];
        CfgLutLow: cfg_d.lut_low        = cfg_data_i;
        CfgLutHi:  cfg_d.lut_high       = cfg_data_i;
        default:   cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ncb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .rom_byte_i   (rom_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  ncb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .room2_i      (room2),
    .push_o       (res_push)
  );

  ncb_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .room2_o (room2),
    .empty   (empty),
    .pop     (pop),
    .head_o  (head)
  );

  // The oldest result stays on the ports while empty is low.
  assign kind_o        = head.kind;
  assign rom_address_o = head.rom_address;
  assign pixel_x_o     = head.pixel_x;
  assign pixel_y_o     = head.pixel_y;
  assign pixel_color_o = head.pixel_color;
  assign pixel_count_o = head.pixel_count;
  assign last_o        = head.last;

endmodule
